// ===== design/fls64_pkg.sv =====
// ---------------------------------------------------------------------------
// fls64_pkg: shared types and constants for the four-lane stripe hash
// Holds the primes, the sequencer states, the multiplier handshake structs
// and the rotate helpers.
// ---------------------------------------------------------------------------
package fls64_pkg;

    localparam logic [63:0] PRIME1 = 64'h9E37_79B1_85EB_CA87;
    localparam logic [63:0] PRIME2 = 64'hC2B2_AE3D_27D4_EB4F;
    localparam logic [63:0] PRIME3 = 64'h1656_67B1_9E37_79F9;
    localparam logic [63:0] PRIME5 = 64'h27D4_EB2F_1656_67C5;

    // lane reset values
    localparam logic [63:0] LANE0_INIT = PRIME1 + PRIME2;
    localparam logic [63:0] LANE1_INIT = PRIME2;
    localparam logic [63:0] LANE2_INIT = 64'd0;
    localparam logic [63:0] LANE3_INIT = 64'd0 - PRIME1;

    localparam int unsigned LANES = 4;
    localparam logic [31:0] STRIPE_BYTES = 32'd32;

    // multiplier: three 32x32 partial products, step 0..2
    localparam logic [1:0] MUL_LAST_STEP = 2'd2;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABS_MUL1,
        ST_ABS_MUL2,
        ST_FIN_SUM,
        ST_FIN_MIX,
        ST_FIN_MUL1,
        ST_FIN_MUL2,
        ST_FIN_OUT
    } fls64_state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } fls64_mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } fls64_mul_rsp_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
        logic [127:0] tmp;
        tmp = {x, x} << r;
        return tmp[127:64];
    endfunction

    function automatic logic [5:0] lane_rot(input logic [1:0] idx);
        logic [5:0] r;
        unique case (idx)
            2'd0: r = 6'd1;
            2'd1: r = 6'd7;
            2'd2: r = 6'd12;
            2'd3: r = 6'd18;
            default: r = 6'd1;
        endcase
        return r;
    endfunction

endpackage

// ===== design/four_lane_stripe_hash64_core.sv =====
// ---------------------------------------------------------------------------
// four_lane_stripe_hash64_core: four-lane stripe hash, top level
// Sequencer, lane accumulators and output register around one shared
// iterative multiplier.
//
//   channel  dir  ports                                   beat
//   s_       in   s_action, s_data_word, s_total_length   absorb word / finish
//   m_       out  m_hash_value                            one hash per finish
//
// Absorb: each beat runs two chained 64-bit multiplies (operand load, three
//   32x32 partial products), the second one writing the lane, and then returns
//   to the idle state that takes the next beat.
// Finish: a lane-sum walk over the four lanes (skipped for length below 32),
//   a mix step, two multiplies, an output load and the idle state.
// s_ready is high only while the sequencer is idle. A finished hash sits in
//   the output register; while m_ready stalls it, the next finish waits in
//   ST_FIN_OUT with s_ready low.
// Reset (synchronous, active low) restores the lane reset values at once.
// ---------------------------------------------------------------------------
module four_lane_stripe_hash64_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [63:0] s_data_word,
    input  logic [31:0] s_total_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_value
);

    fls64_pkg::fls64_state_t state_reg, state_next;

    logic [63:0] lane_acc_reg  [fls64_pkg::LANES];
    logic [63:0] lane_acc_next [fls64_pkg::LANES];
    logic [1:0]  lane_index_reg, lane_index_next;
    logic [1:0]  sum_idx_reg, sum_idx_next;
    logic [63:0] h_reg, h_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_hash_reg, m_hash_next;

    fls64_pkg::fls64_mul_req_t mul_req;
    fls64_pkg::fls64_mul_rsp_t mul_rsp;

    logic [1:0]  lane_sel;
    logic [63:0] lane_rd;
    logic [63:0] abs_sum;
    logic        s_fire;

    fls64_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    assign s_ready = (state_reg == fls64_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // single lane read port: lane-sum walk or the lane being absorbed
    assign lane_sel = (state_reg == fls64_pkg::ST_FIN_SUM) ? sum_idx_reg : lane_index_reg;
    assign lane_rd  = lane_acc_reg[lane_sel];
    assign abs_sum  = lane_rd + mul_rsp.product;

    always_comb begin
        state_next      = state_reg;
        lane_acc_next   = lane_acc_reg;
        lane_index_next = lane_index_reg;
        sum_idx_next    = sum_idx_reg;
        h_next          = h_reg;
        m_hash_next     = m_hash_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        mul_req.start   = 1'b0;
        mul_req.a       = s_data_word;
        mul_req.b       = fls64_pkg::PRIME2;

        unique case (state_reg)
            fls64_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_action == fls64_pkg::ACT_ABSORB) begin
                        mul_req.start = 1'b1;
                        state_next    = fls64_pkg::ST_ABS_MUL1;
                    end else if (s_total_length >= fls64_pkg::STRIPE_BYTES) begin
                        h_next       = fls64_pkg::rotl64(lane_acc_reg[0], 6'd1)
                                       + fls64_pkg::PRIME5;
                        sum_idx_next = 2'd1;
                        state_next   = fls64_pkg::ST_FIN_SUM;
                    end else begin
                        h_next     = {32'd0, s_total_length} + fls64_pkg::PRIME5;
                        state_next = fls64_pkg::ST_FIN_MIX;
                    end
                end
            end
            fls64_pkg::ST_ABS_MUL1: begin
                mul_req.a = fls64_pkg::rotl64(abs_sum, 6'd31);
                mul_req.b = fls64_pkg::PRIME1;
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    state_next    = fls64_pkg::ST_ABS_MUL2;
                end
            end
            fls64_pkg::ST_ABS_MUL2: begin
                if (mul_rsp.done) begin
                    lane_acc_next[lane_index_reg] = mul_rsp.product;
                    lane_index_next = lane_index_reg + 2'd1;
                    state_next      = fls64_pkg::ST_IDLE;
                end
            end
            fls64_pkg::ST_FIN_SUM: begin
                h_next = h_reg + fls64_pkg::rotl64(lane_rd, fls64_pkg::lane_rot(sum_idx_reg));
                if (sum_idx_reg == 2'd3) begin
                    state_next = fls64_pkg::ST_FIN_MIX;
                end else begin
                    sum_idx_next = sum_idx_reg + 2'd1;
                end
            end
            fls64_pkg::ST_FIN_MIX: begin
                mul_req.start = 1'b1;
                mul_req.a     = h_reg ^ (h_reg >> 33);
                mul_req.b     = fls64_pkg::PRIME2;
                state_next    = fls64_pkg::ST_FIN_MUL1;
            end
            fls64_pkg::ST_FIN_MUL1: begin
                mul_req.a = mul_rsp.product ^ (mul_rsp.product >> 29);
                mul_req.b = fls64_pkg::PRIME3;
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    state_next    = fls64_pkg::ST_FIN_MUL2;
                end
            end
            fls64_pkg::ST_FIN_MUL2: begin
                if (mul_rsp.done) begin
                    h_next     = mul_rsp.product ^ (mul_rsp.product >> 32);
                    state_next = fls64_pkg::ST_FIN_OUT;
                end
            end
            fls64_pkg::ST_FIN_OUT: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    m_hash_next      = h_reg;
                    m_valid_next     = 1'b1;
                    lane_acc_next[0] = fls64_pkg::LANE0_INIT;
                    lane_acc_next[1] = fls64_pkg::LANE1_INIT;
                    lane_acc_next[2] = fls64_pkg::LANE2_INIT;
                    lane_acc_next[3] = fls64_pkg::LANE3_INIT;
                    lane_index_next  = 2'd0;
                    state_next       = fls64_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fls64_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= fls64_pkg::ST_IDLE;
            lane_acc_reg[0] <= fls64_pkg::LANE0_INIT;
            lane_acc_reg[1] <= fls64_pkg::LANE1_INIT;
            lane_acc_reg[2] <= fls64_pkg::LANE2_INIT;
            lane_acc_reg[3] <= fls64_pkg::LANE3_INIT;
            lane_index_reg  <= 2'd0;
            sum_idx_reg     <= 2'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            lane_acc_reg   <= lane_acc_next;
            lane_index_reg <= lane_index_next;
            sum_idx_reg    <= sum_idx_next;
            m_valid_reg    <= m_valid_next;
        end
        h_reg      <= h_next;
        m_hash_reg <= m_hash_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

endmodule

// ===== design/fls64_mul.sv =====
// ---------------------------------------------------------------------------
// fls64_mul: iterative 64x64 multiplier, low 64 bits of the product
// One 32x32 multiplier is reused in turn: lo*lo, then the two
// cross products added into the upper half. done pulses in the cycle after
// the last step; product holds until the next start.
// ---------------------------------------------------------------------------
module fls64_mul (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  fls64_pkg::fls64_mul_req_t req,
    output fls64_pkg::fls64_mul_rsp_t rsp
);

    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] part;

    always_comb begin
        unique case (step_reg)
            2'd0:    begin op_a = a_reg[31:0];  op_b = b_reg[31:0];  end
            2'd1:    begin op_a = a_reg[31:0];  op_b = b_reg[63:32]; end
            default: begin op_a = a_reg[63:32]; op_b = b_reg[31:0];  end
        endcase
        part = op_a * op_b;
    end

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            a_next    = req.a;
            b_next    = req.b;
            step_next = 2'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (step_reg == 2'd0) begin
                acc_next = part;
            end else begin
                // cross products only reach the upper half
                acc_next[63:32] = acc_reg[63:32] + part[31:0];
            end
            if (step_reg == fls64_pkg::MUL_LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// ===== design/fls64_checker.sv =====
// ---------------------------------------------------------------------------
// fls64_checker: port-level checks for the four-lane stripe hash
// Watches the top-level ports only; bound to the top level below.
// ---------------------------------------------------------------------------
module fls64_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_action,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_hash_value
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // stalled hash beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hash_value))
        else $error("stalled hash beat changed");

    // block is busy the cycle after any accepted beat
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready high right after an accepted beat");

    // an absorb beat never produces a hash
    a_absorb_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_action && !m_valid |=> !m_valid)
        else $error("hash appeared after absorb beat");

    // no hash appears early after a finish beat
    a_finish_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_action && !m_valid |=> !m_valid ##1 !m_valid)
        else $error("hash appeared too early after finish beat");

endmodule

bind four_lane_stripe_hash64_core fls64_checker u_fls64_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_action     (s_action),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hash_value (m_hash_value)
);
